### rtl/core/pir_pkg.sv
// Shared types and constants for the packed image run decoder.
package pir_pkg;

    localparam int unsigned CFG_ADDR_WIDTH = 4;
    localparam int unsigned QUEUE_DEPTH    = 2;
    localparam int unsigned QUEUE_AW       = 1;

    localparam logic [12:0] MIN_WIDTH      = 13'd80;
    localparam logic [12:0] RESET_WIDTH    = 13'd320;
    localparam logic [11:0] MAX_RUN_COLOR  = 12'd2047;
    localparam logic [11:0] COLOR_BIAS     = 12'd2048;
    localparam logic [12:0] LITERAL_LENGTH = 13'd1;

    typedef enum logic [1:0] {
        REG_PICTURE_WIDTH = 2'd0,
        REG_ORIGIN_X      = 2'd1,
        REG_ORIGIN_Y      = 2'd2,
        REG_UNUSED        = 2'd3
    } t_reg_index;

    typedef struct packed {
        logic [23:0] record;
        logic        first_record;
    } t_in_item;

    typedef struct packed {
        logic [12:0] span_x;
        logic [12:0] span_y;
        logic [12:0] span_length;
        logic [10:0] color_index;
        logic        last_of_record;
    } t_out_item;

    typedef struct packed {
        logic [12:0] picture_width;
        logic [11:0] origin_x;
        logic [11:0] origin_y;
    } t_cfg;

    typedef struct packed {
        logic        is_literal;
        logic        is_empty;
        logic        first;
        logic [10:0] color;
        logic [11:0] arg;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_LIT0 = 2'd1,
        ST_LIT1 = 2'd2,
        ST_RUN  = 2'd3
    } t_back_state;

endpackage

### rtl/core/packed_image_run_decoder.sv
// Top level of the packed image run decoder with its configuration registers.
//
//   port group   direction  handshake              payload
//   record in    input      i_in_valid/o_in_stall  i_in_data  (t_in_item)
//   span out     output     o_out_valid/i_out_stall o_out_data (t_out_item)
//   config       input      psel/penable/pready    paddr, pwdata, prdata
//
// A record passes the front register and the two-entry command queue; the
// back stage pops it from its idle state, then emits one span for a run
// within one row, two for a literal pair, and one more for each further row
// a run crosses; an initial row wrap is a step of its own with no span.
// The back-stage sequencer emits one span per cycle unless the output stalls.
// Reset is synchronous and active low; it clears the cursor and restores
// the register defaults. An output stall holds the span register, and the
// queue lets the front keep taking records meanwhile.
module packed_image_run_decoder #(
    parameter int unsigned COORD_WIDTH = 13
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  pir_pkg::t_in_item                    i_in_data,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output pir_pkg::t_out_item                   o_out_data,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [pir_pkg::CFG_ADDR_WIDTH-1:0]   paddr,
    input  logic [31:0]                          pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready
);
    import pir_pkg::*;

    t_cfg          r_cfg;
    t_reg_index    reg_index;
    logic          cfg_write;
    logic          push;
    logic          pop;
    t_cmd          front_cmd;
    t_cmd          queue_cmd;
    t_queue_status q_status;

    assign pready    = 1'b1;
    assign reg_index = t_reg_index'(paddr[3:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.picture_width <= RESET_WIDTH;
            r_cfg.origin_x      <= '0;
            r_cfg.origin_y      <= '0;
        end else if (cfg_write) begin
            unique case (reg_index)
                REG_PICTURE_WIDTH: r_cfg.picture_width <= pwdata[12:0];
                REG_ORIGIN_X:      r_cfg.origin_x      <= pwdata[11:0];
                REG_ORIGIN_Y:      r_cfg.origin_y      <= pwdata[11:0];
                default:           r_cfg               <= r_cfg;
            endcase
        end
    end

    always_comb begin
        unique case (reg_index)
            REG_PICTURE_WIDTH: prdata = 32'(r_cfg.picture_width);
            REG_ORIGIN_X:      prdata = 32'(r_cfg.origin_x);
            REG_ORIGIN_Y:      prdata = 32'(r_cfg.origin_y);
            default:           prdata = '0;
        endcase
    end

    pir_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .i_q_status (q_status),
        .o_push     (push),
        .o_cmd      (front_cmd)
    );

    pir_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_cmd    (front_cmd),
        .i_pop    (pop),
        .o_cmd    (queue_cmd),
        .o_status (q_status)
    );

    pir_back #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd       (queue_cmd),
        .i_q_status  (q_status),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

### rtl/core/pir_front.sv
// Front stage: accepts records and classifies them into decode commands.
module pir_front (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  pir_pkg::t_in_item      i_in_data,
    input  pir_pkg::t_queue_status i_q_status,
    output logic                   o_push,
    output pir_pkg::t_cmd          o_cmd
);
    import pir_pkg::*;

    logic        r_valid;
    t_cmd        r_cmd;
    t_cmd        n_cmd;
    logic        accept;
    logic [11:0] code_a;
    logic [11:0] code_b;
    logic [11:0] color_full;

    assign code_a     = i_in_data.record[23:12];
    assign code_b     = i_in_data.record[11:0];
    assign o_in_stall = r_valid && i_q_status.full;
    assign accept     = i_in_valid && !o_in_stall;
    assign o_push     = r_valid && !i_q_status.full;
    assign o_cmd      = r_cmd;

    always_comb begin
        n_cmd.is_literal = code_a > MAX_RUN_COLOR;
        n_cmd.is_empty   = (code_b == 12'd0);
        n_cmd.first      = i_in_data.first_record;
        color_full       = n_cmd.is_literal ? (code_a - COLOR_BIAS) : code_a;
        n_cmd.color      = color_full[10:0];
        n_cmd.arg        = code_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

### rtl/core/pir_queue.sv
// Short command queue between the front and back stages.
module pir_queue (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  pir_pkg::t_cmd          i_cmd,
    input  logic                   i_pop,
    output pir_pkg::t_cmd          o_cmd,
    output pir_pkg::t_queue_status o_status
);
    import pir_pkg::*;

    t_cmd                r_slot [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr;
    logic [QUEUE_AW:0]   r_count;

    assign o_cmd          = r_slot[r_rd_ptr];
    assign o_status.full  = (r_count == (QUEUE_AW + 1)'(QUEUE_DEPTH));
    assign o_status.empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

### rtl/core/pir_back.sv
// Back stage: keeps the cursor; up to one span per cycle into the output register.
module pir_back #(
    parameter int unsigned COORD_WIDTH = 13
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  pir_pkg::t_cfg          i_cfg,
    input  pir_pkg::t_cmd          i_cmd,
    input  pir_pkg::t_queue_status i_q_status,
    output logic                   o_pop,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output pir_pkg::t_out_item     o_out_data
);
    import pir_pkg::*;

    localparam int unsigned EW = ((COORD_WIDTH > 14) ? COORD_WIDTH : 14) + 1;

    t_back_state             r_state;
    t_back_state             n_state;
    t_cmd                    r_cmd;
    logic [COORD_WIDTH-1:0]  r_cur_x;
    logic [COORD_WIDTH-1:0]  r_cur_y;
    logic [COORD_WIDTH-1:0]  n_cur_x;
    logic [COORD_WIDTH-1:0]  n_cur_y;
    logic [11:0]             r_n;
    logic [11:0]             n_n;
    logic                    r_out_valid;
    t_out_item               r_out;
    t_out_item               emit_item;
    logic                    emit;

    logic                    can_emit;
    logic [12:0]             width_eff;
    logic [EW-1:0]           row_end;
    logic [EW-1:0]           ox_ext;
    logic [EW-1:0]           oy_ext;
    logic [EW-1:0]           cur_x_ext;
    logic [EW-1:0]           cur_y_ext;
    logic [EW-1:0]           run_sum;
    logic [EW-1:0]           run_len;
    logic [11:0]             run_rest;
    logic [COORD_WIDTH-1:0]  lit_next;
    logic                    lit_wrap;
    logic                    pre_wrap;
    logic                    run_cross;
    logic                    run_done;

    assign can_emit  = !r_out_valid || !i_out_stall;
    assign width_eff = (i_cfg.picture_width < MIN_WIDTH) ? MIN_WIDTH : i_cfg.picture_width;
    assign ox_ext    = EW'(i_cfg.origin_x);
    assign oy_ext    = EW'(i_cfg.origin_y);
    assign row_end   = EW'(width_eff) + ox_ext;
    assign cur_x_ext = EW'(r_cur_x);
    assign cur_y_ext = EW'(r_cur_y);
    assign run_sum   = cur_x_ext + EW'(r_n);
    assign run_len   = row_end - cur_x_ext;
    assign run_rest  = r_n - run_len[11:0];
    assign lit_next  = r_cur_x + 1'b1;
    assign lit_wrap  = EW'(lit_next) >= row_end;
    assign pre_wrap  = cur_x_ext >= row_end;
    assign run_cross = run_sum >= row_end;
    assign run_done  = !run_cross || (run_rest == 12'd0);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (!i_q_status.empty) begin
                    if (i_cmd.is_literal) begin
                        n_state = ST_LIT0;
                    end else if (!i_cmd.is_empty) begin
                        n_state = ST_RUN;
                    end
                end
            end
            ST_LIT0: begin
                if (can_emit) begin
                    n_state = ST_LIT1;
                end
            end
            ST_LIT1: begin
                if (can_emit) begin
                    n_state = ST_IDLE;
                end
            end
            ST_RUN: begin
                if (!pre_wrap && can_emit && run_done) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_pop                    = 1'b0;
        emit                     = 1'b0;
        n_cur_x                  = r_cur_x;
        n_cur_y                  = r_cur_y;
        n_n                      = r_n;
        emit_item.span_x         = cur_x_ext[12:0];
        emit_item.span_y         = cur_y_ext[12:0];
        emit_item.span_length    = LITERAL_LENGTH;
        emit_item.color_index    = r_cmd.color;
        emit_item.last_of_record = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (!i_q_status.empty) begin
                    o_pop = 1'b1;
                    n_n   = i_cmd.arg;
                    if (i_cmd.first) begin
                        n_cur_x = ox_ext[COORD_WIDTH-1:0];
                        n_cur_y = oy_ext[COORD_WIDTH-1:0];
                    end
                end
            end
            ST_LIT0, ST_LIT1: begin
                if (can_emit) begin
                    emit = 1'b1;
                    if (r_state == ST_LIT1) begin
                        emit_item.color_index    = r_n[10:0];
                        emit_item.last_of_record = 1'b1;
                    end
                    if (lit_wrap) begin
                        n_cur_x = ox_ext[COORD_WIDTH-1:0];
                        n_cur_y = r_cur_y + 1'b1;
                    end else begin
                        n_cur_x = lit_next;
                    end
                end
            end
            ST_RUN: begin
                if (pre_wrap) begin
                    n_cur_x = ox_ext[COORD_WIDTH-1:0];
                    n_cur_y = r_cur_y + 1'b1;
                end else if (can_emit) begin
                    emit                     = 1'b1;
                    emit_item.last_of_record = run_done;
                    if (run_cross) begin
                        emit_item.span_length = 13'(run_len[11:0]);
                        n_n                   = run_rest;
                        n_cur_x               = ox_ext[COORD_WIDTH-1:0];
                        n_cur_y               = r_cur_y + 1'b1;
                    end else begin
                        emit_item.span_length = 13'(r_n);
                        n_cur_x               = run_sum[COORD_WIDTH-1:0];
                    end
                end
            end
            default: begin
                emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cur_x     <= '0;
            r_cur_y     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cur_x <= n_cur_x;
            r_cur_y <= n_cur_y;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_n <= n_n;
        if (o_pop) begin
            r_cmd <= i_cmd;
        end
        if (emit) begin
            r_out <= emit_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

### tb/pir_span_checker.sv
// Span checker for the packed image run decoder: predicts every span and compares it.
module pir_span_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    input  logic                               i_in_stall,
    input  pir_pkg::t_in_item                  i_in_data,
    input  logic                               i_out_valid,
    input  logic                               i_out_stall,
    input  pir_pkg::t_out_item                 i_out_data,
    input  logic                               i_psel,
    input  logic                               i_penable,
    input  logic                               i_pwrite,
    input  logic [pir_pkg::CFG_ADDR_WIDTH-1:0] i_paddr,
    input  logic [31:0]                        i_pwdata,
    input  logic [31:0]                        i_prdata,
    input  logic                               i_pready,
    output int                                 o_errors,
    output int                                 o_pending
);
    import pir_pkg::*;

    logic [12:0] cfg_width;
    logic [11:0] cfg_origin_x;
    logic [11:0] cfg_origin_y;
    logic [12:0] cur_x;
    logic [12:0] cur_y;

    t_out_item   span_queue[$];
    t_out_item   held_span;
    logic        held_valid;
    t_out_item   want_span;
    int          mismatch_count = 0;

    initial begin
        o_errors  = 0;
        o_pending = 0;
    end

    task automatic next_row();
        cur_x = {1'b0, cfg_origin_x};
        cur_y = cur_y + 13'd1;
    endtask

    // The newest span is held back so that the record's last one can be flagged.
    task automatic queue_span(input logic [12:0] x, input logic [12:0] y,
                              input logic [12:0] len, input logic [10:0] color);
        if (held_valid) begin
            span_queue.push_back(held_span);
        end
        held_span.span_x         = x;
        held_span.span_y         = y;
        held_span.span_length    = len;
        held_span.color_index    = color;
        held_span.last_of_record = 1'b0;
        held_valid               = 1'b1;
    endtask

    task automatic decode_record(input t_in_item item);
        logic [11:0] code_a;
        logic [11:0] code_b;
        logic [11:0] lit_color;
        int unsigned row_limit;
        int unsigned remaining;
        int unsigned len;
        int unsigned eff_width;
        int          emitted;
        code_a    = item.record[23:12];
        code_b    = item.record[11:0];
        eff_width = (cfg_width < MIN_WIDTH) ? 32'(MIN_WIDTH) : 32'(cfg_width);
        row_limit = 32'(cfg_origin_x) + eff_width;
        emitted   = 0;
        if (item.first_record) begin
            cur_x = {1'b0, cfg_origin_x};
            cur_y = {1'b0, cfg_origin_y};
        end
        if (code_a > MAX_RUN_COLOR) begin
            lit_color = code_a - COLOR_BIAS;
            queue_span(cur_x, cur_y, LITERAL_LENGTH, lit_color[10:0]);
            cur_x = cur_x + 13'd1;
            if (32'(cur_x) >= row_limit) next_row();
            queue_span(cur_x, cur_y, LITERAL_LENGTH, code_b[10:0]);
            cur_x = cur_x + 13'd1;
            if (32'(cur_x) >= row_limit) next_row();
        end else if (code_b != 12'd0) begin
            remaining = 32'(code_b);
            if (32'(cur_x) >= row_limit) next_row();
            while (remaining > 0 && 32'(cur_x) + remaining >= row_limit && emitted < 64) begin
                len = row_limit - 32'(cur_x);
                queue_span(cur_x, cur_y, len[12:0], code_a[10:0]);
                remaining = remaining - len;
                emitted++;
                next_row();
            end
            if (remaining > 0 && emitted < 64) begin
                queue_span(cur_x, cur_y, remaining[12:0], code_a[10:0]);
                cur_x = cur_x + remaining[12:0];
            end
        end
        if (held_valid) begin
            held_span.last_of_record = 1'b1;
            span_queue.push_back(held_span);
            held_valid = 1'b0;
        end
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_width    = RESET_WIDTH;
            cfg_origin_x = '0;
            cfg_origin_y = '0;
            cur_x        = '0;
            cur_y        = '0;
            held_valid   = 1'b0;
            span_queue.delete();
        end else begin
            if (i_psel && i_penable && !i_pwrite && i_pready) begin
                case (t_reg_index'(i_paddr[3:2]))
                    REG_PICTURE_WIDTH: check_field("picture_width", 32'(cfg_width), i_prdata);
                    REG_ORIGIN_X:      check_field("origin_x", 32'(cfg_origin_x), i_prdata);
                    REG_ORIGIN_Y:      check_field("origin_y", 32'(cfg_origin_y), i_prdata);
                    default: ;
                endcase
            end
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (t_reg_index'(i_paddr[3:2]))
                    REG_PICTURE_WIDTH: cfg_width    = i_pwdata[12:0];
                    REG_ORIGIN_X:      cfg_origin_x = i_pwdata[11:0];
                    REG_ORIGIN_Y:      cfg_origin_y = i_pwdata[11:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                decode_record(i_in_data);
            end
            if (i_out_valid && !i_out_stall) begin
                if (span_queue.size() == 0) begin
                    $display("%0t: span expected none actual x=%0d y=%0d len=%0d color=%0d last=%0d",
                             $time, i_out_data.span_x, i_out_data.span_y,
                             i_out_data.span_length, i_out_data.color_index,
                             i_out_data.last_of_record);
                    mismatch_count++;
                end else begin
                    want_span = span_queue.pop_front();
                    check_field("span_x", 32'(want_span.span_x),
                                32'(i_out_data.span_x));
                    check_field("span_y", 32'(want_span.span_y),
                                32'(i_out_data.span_y));
                    check_field("span_length", 32'(want_span.span_length),
                                32'(i_out_data.span_length));
                    check_field("color_index", 32'(want_span.color_index),
                                32'(i_out_data.color_index));
                    check_field("last_of_record", 32'(want_span.last_of_record),
                                32'(i_out_data.last_of_record));
                end
            end
        end
        o_errors  = mismatch_count;
        o_pending = span_queue.size();
    end

endmodule

### tb/packed_image_run_decoder_tb.sv
// Testbench top for the packed image run decoder: drives records and registers, gives the verdict.
module packed_image_run_decoder_tb;

    import pir_pkg::*;

    localparam int CLK_PERIOD    = 12;
    localparam int RESET_CYCLES  = 11;
    localparam int CYCLE_LIMIT   = 3000000;
    localparam int SETTLE_CYCLES = 24;
    localparam int PHASE_COUNT   = 8;
    localparam int PHASE_ITEMS   = 32;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_in_valid;
    logic                      o_in_stall;
    t_in_item                  i_in_data;
    logic                      o_out_valid;
    logic                      i_out_stall;
    t_out_item                 o_out_data;
    logic                      psel;
    logic                      penable;
    logic                      pwrite;
    logic [CFG_ADDR_WIDTH-1:0] paddr;
    logic [31:0]               pwdata;
    logic [31:0]               prdata;
    logic                      pready;

    int   error_count;
    int   spans_pending;
    int   cycle_count = 0;
    logic steady;

    logic [12:0] phase_width[PHASE_COUNT] = '{13'd320, 13'd80, 13'd4096, 13'd79,
                                              13'd8191, 13'd640, 13'd81, 13'd1024};
    logic [11:0] phase_ox[PHASE_COUNT]    = '{12'd0, 12'd0, 12'd4095, 12'd1000,
                                              12'd2048, 12'd13, 12'd4000, 12'd0};
    logic [11:0] phase_oy[PHASE_COUNT]    = '{12'd0, 12'd0, 12'd4095, 12'd7,
                                              12'd100, 12'd4000, 12'd0, 12'd2000};

    packed_image_run_decoder dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    pir_span_checker span_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .i_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_out_data  (o_out_data),
        .i_psel      (psel),
        .i_penable   (penable),
        .i_pwrite    (pwrite),
        .i_paddr     (paddr),
        .i_pwdata    (pwdata),
        .i_prdata    (prdata),
        .i_pready    (pready),
        .o_errors    (error_count),
        .o_pending   (spans_pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("packed_image_run_decoder_tb: errors");
            $finish;
        end
    end

    initial begin
        int mode;
        int run_free;
        int run_stall;
        i_out_stall = 1'b0;
        forever begin
            mode = $urandom_range(0, 99);
            if (mode < 70) begin
                run_free  = $urandom_range(1, 6);
                run_stall = $urandom_range(1, 3);
            end else if (mode < 80) begin
                run_free  = $urandom_range(1, 4);
                run_stall = $urandom_range(10, 40);
            end else begin
                run_free  = $urandom_range(40, 200);
                run_stall = 0;
            end
            @(negedge i_clk) i_out_stall = 1'b0;
            repeat (run_free - 1) @(negedge i_clk);
            if (run_stall > 0) begin
                @(negedge i_clk) i_out_stall = 1'b1;
                repeat (run_stall - 1) @(negedge i_clk);
            end
        end
    end

    function automatic t_in_item make_item(input logic [11:0] code_a,
                                           input logic [11:0] code_b,
                                           input logic first);
        t_in_item item;
        item.record       = {code_a, code_b};
        item.first_record = first;
        return item;
    endfunction

    function automatic t_in_item random_record();
        int          pick;
        logic [11:0] code_a;
        logic [11:0] code_b;
        logic        first;
        pick  = $urandom_range(0, 99);
        first = ($urandom_range(0, 99) < 8);
        if (pick < 35) begin
            code_a = 12'($urandom_range(2048, 4095));
            code_b = 12'($urandom_range(0, 4095));
        end else if (pick < 65) begin
            code_a = 12'($urandom_range(0, 2047));
            code_b = 12'($urandom_range(1, 100));
        end else if (pick < 75) begin
            code_a = 12'($urandom_range(0, 2047));
            code_b = 12'($urandom_range(1, 4095));
        end else if (pick < 80) begin
            code_a = 12'($urandom_range(0, 2047));
            code_b = 12'd0;
        end else begin
            code_a = 12'($urandom_range(0, 4095));
            code_b = 12'($urandom_range(0, 4095));
        end
        return make_item(code_a, code_b, first);
    endfunction

    function automatic int pick_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 50) return 0;
        if (pick < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_record(input t_in_item item);
        int gap;
        @(negedge i_clk);
        i_in_valid = 1'b1;
        i_in_data  = item;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        gap = steady ? 0 : pick_gap();
        if (gap > 0) begin
            @(negedge i_clk) i_in_valid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic wait_idle();
        @(negedge i_clk) i_in_valid = 1'b0;
        while (spans_pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic apb_access(input logic write, input t_reg_index idx,
                              input logic [31:0] value);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = write;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge i_clk) penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    // Bits above the register width carry random junk that the block must drop.
    task automatic write_reg(input t_reg_index idx, input logic [31:0] value);
        logic [31:0] keep;
        case (idx)
            REG_PICTURE_WIDTH: keep = 32'h0000_1FFF;
            REG_UNUSED:        keep = 32'h0000_0000;
            default:           keep = 32'h0000_0FFF;
        endcase
        wait_idle();
        apb_access(1'b1, idx, ($urandom & ~keep) | (value & keep));
        apb_access(1'b0, idx, 32'h0);
    endtask

    initial begin
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_data  = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        steady     = 1'b0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n = 1'b1;

        send_record(make_item(12'd0, 12'd0, 1'b1));
        send_record(make_item(12'd5, 12'd320, 1'b0));
        send_record(make_item(12'hFFF, 12'hFFF, 1'b0));
        send_record(make_item(12'd2048, 12'd5, 1'b0));
        send_record(make_item(12'd2047, 12'd4095, 1'b0));
        send_record(make_item(12'd7, 12'd319, 1'b1));
        send_record(make_item(12'd2100, 12'd2900, 1'b0));
        send_record(make_item(12'd9, 12'd0, 1'b0));
        send_record(make_item(12'd1, 12'd1, 1'b0));

        write_reg(REG_PICTURE_WIDTH, 32'hFFFF_FFFF);
        write_reg(REG_ORIGIN_X, 32'hFFFF_FFFF);
        write_reg(REG_ORIGIN_Y, 32'hFFFF_FFFF);
        write_reg(REG_UNUSED, 32'hFFFF_FFFF);
        send_record(make_item(12'd3, 12'd4095, 1'b1));
        send_record(make_item(12'd4, 12'd4095, 1'b0));
        send_record(make_item(12'h800, 12'h7FF, 1'b0));
        send_record(make_item(12'd11, 12'd2, 1'b0));

        // Narrow width with the cursor already far past the new row end.
        write_reg(REG_PICTURE_WIDTH, 32'd79);
        write_reg(REG_ORIGIN_X, 32'd0);
        send_record(make_item(12'd3, 12'd10, 1'b0));

        // Origin moved right of the cursor without a reload.
        write_reg(REG_ORIGIN_X, 32'd200);
        send_record(make_item(12'd4, 12'd500, 1'b0));
        send_record(make_item(12'd3000, 12'd1234, 1'b0));

        for (int p = 0; p < PHASE_COUNT; p++) begin
            write_reg(REG_PICTURE_WIDTH, 32'(phase_width[p]));
            write_reg(REG_ORIGIN_X, 32'(phase_ox[p]));
            write_reg(REG_ORIGIN_Y, 32'(phase_oy[p]));
            steady = (p == 2);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                send_record(random_record());
            end
        end
        steady = 1'b0;

        wait_idle();
        if (error_count == 0 && spans_pending == 0) begin
            $display("packed_image_run_decoder_tb: clean");
        end else begin
            $display("packed_image_run_decoder_tb: errors");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/core/pir_pkg.sv
rtl/core/pir_front.sv
rtl/core/pir_queue.sv
rtl/core/pir_back.sv
rtl/core/packed_image_run_decoder.sv
tb/pir_span_checker.sv
tb/packed_image_run_decoder_tb.sv
